>>> hdl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared request and result types and default sizes.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int CODE_BITS_DEF    = 16;
  localparam int DICT_ENTRIES_DEF = 65278;
  localparam int EPOCH_BITS       = 8;
  localparam int MAX_RESULTS      = 4;
  localparam int FIRST_CODE       = 256;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_word;
    logic        last_code;
  } out_item_t;

endpackage

>>> hdl/lzw_slot_ram.sv
// ----------------------------------------------------------------------------
// LZW hash slot memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzw_slot_ram #(
  parameter int ADDR_BITS = 17,
  parameter int DATA_BITS = 48
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/lzw_byte_compressor.sv
// ----------------------------------------------------------------------------
// LZW byte compressor
// Greedy LZW over a byte stream, dictionary in a linear-probed hash memory.
// ----------------------------------------------------------------------------
// Steps: a byte that starts a match goes straight to the finish state; otherwise the
//   wait and check states repeat per hash probe through the slot memory read port, then
//   up to four result codes go out as out_ready allows. One request at a time; the next
//   request waits until every result code is taken.
// Reset: synchronous, active low; a pass over all 2^(CODE_BITS+1) hash slots
//   follows reset and every 255th dictionary clear, with in_ready low.
module lzw_byte_compressor #(
  parameter int CODE_BITS    = lzw_pkg::CODE_BITS_DEF,
  parameter int DICT_ENTRIES = lzw_pkg::DICT_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lzw_pkg::out_item_t out_data
);

  localparam int HB  = CODE_BITS + 1;
  localparam int EB  = lzw_pkg::EPOCH_BITS;
  localparam int KB  = CODE_BITS + 8;
  localparam int SB  = EB + CODE_BITS + KB;
  localparam int CLR_CODE_I = (1 << CODE_BITS) - 2;
  localparam int FULL_I = (lzw_pkg::FIRST_CODE + DICT_ENTRIES < CLR_CODE_I) ?
                          (lzw_pkg::FIRST_CODE + DICT_ENTRIES) : CLR_CODE_I;
  localparam logic [15:0] CLEAR_CODE = 16'(CLR_CODE_I);
  localparam logic [15:0] END_CODE   = 16'((1 << CODE_BITS) - 1);
  localparam logic [CODE_BITS:0] FULL_MARK = (CODE_BITS+1)'(FULL_I);
  localparam logic [CODE_BITS-1:0] FIRST = CODE_BITS'(lzw_pkg::FIRST_CODE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CODE_BITS-1:0] cur_r, cur_nxt;
  logic                 active_r, active_nxt;
  logic [CODE_BITS-1:0] nf_r, nf_nxt;
  logic [EB-1:0]        epoch_r, epoch_nxt;
  logic                 wrap_r, wrap_nxt;
  logic [HB-1:0]        addr_r, addr_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;
  logic [15:0]          res_r [lzw_pkg::MAX_RESULTS];
  logic [15:0]          res_nxt [lzw_pkg::MAX_RESULTS];
  logic [2:0]           cnt_r, cnt_nxt;
  logic [1:0]           idx_r, idx_nxt;

  logic [SB-1:0]        rd_slot;
  logic [SB-1:0]        wr_slot;
  logic                 wr_en;
  logic [EB-1:0]        slot_epoch;
  logic [CODE_BITS-1:0] slot_code;
  logic [KB-1:0]        slot_key;
  logic [KB-1:0]        key;
  logic                 live;
  logic [CODE_BITS:0]   nf_inc;
  logic [EB-1:0]        ep_a;
  logic                 out_last;

  assign {slot_epoch, slot_code, slot_key} = rd_slot;
  assign key    = {cur_r, byte_r};
  assign live   = (slot_epoch == epoch_r);
  assign nf_inc = {1'b0, nf_r} + 1'b1;

  lzw_slot_ram #(
    .ADDR_BITS (HB),
    .DATA_BITS (SB)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_slot),
    .rd_addr (addr_r),
    .rd_data (rd_slot)
  );

  assign wr_en   = (state_r == S_CLR) || ((state_r == S_CHK) && !live);
  assign wr_slot = (state_r == S_CLR) ? '0 : {epoch_r, nf_r, key};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_last  = ({1'b0, idx_r} == cnt_r - 3'd1);
  assign out_data.code_word = res_r[idx_r];
  assign out_data.last_code = out_last;

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    active_nxt = active_r;
    nf_nxt     = nf_r;
    epoch_nxt  = epoch_r;
    wrap_nxt   = wrap_r;
    addr_nxt   = addr_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    ep_a       = epoch_r + 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.data_byte;
          last_nxt = in_data.last_byte;
          cnt_nxt  = '0;
          if (!active_r) begin
            cur_nxt    = CODE_BITS'(in_data.data_byte);
            active_nxt = 1'b1;
            state_nxt  = S_FIN;
          end else begin
            addr_nxt  = HB'(cur_r) ^ (HB'(in_data.data_byte) << (HB - 8))
                        ^ HB'(in_data.data_byte);
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (live && slot_key == key) begin
          cur_nxt   = slot_code;
          state_nxt = S_FIN;
        end else if (live) begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_WAIT;
        end else begin
          res_nxt[0] = 16'(cur_r);
          cnt_nxt    = 3'd1;
          cur_nxt    = CODE_BITS'(byte_r);
          if (nf_inc >= FULL_MARK) begin
            res_nxt[1] = CLEAR_CODE;
            cnt_nxt    = 3'd2;
            nf_nxt     = FIRST;
            if (ep_a == '0) begin
              epoch_nxt = EB'(1);
              wrap_nxt  = 1'b1;
            end else begin
              epoch_nxt = ep_a;
            end
          end else begin
            nf_nxt = nf_inc[CODE_BITS-1:0];
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (last_r) begin
          res_nxt[cnt_r[1:0]]        = 16'(cur_r);
          res_nxt[cnt_r[1:0] + 2'd1] = END_CODE;
          cnt_nxt    = cnt_r + 3'd2;
          cur_nxt    = '0;
          active_nxt = 1'b0;
          nf_nxt     = FIRST;
          if (ep_a == '0) begin
            epoch_nxt = EB'(1);
            wrap_nxt  = 1'b1;
          end else begin
            epoch_nxt = ep_a;
          end
          state_nxt = S_EMIT;
        end else if (cnt_r != 3'd0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = wrap_r ? S_CLR : S_IDLE;
        end
        idx_nxt  = '0;
        addr_nxt = '0;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (out_last) begin
            state_nxt = wrap_r ? S_CLR : S_IDLE;
            addr_nxt  = '0;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      S_CLR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == {HB{1'b1}}) begin
          wrap_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      cur_r    <= '0;
      active_r <= 1'b0;
      nf_r     <= FIRST;
      epoch_r  <= EB'(1);
      wrap_r   <= 1'b1;
      addr_r   <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      active_r <= active_nxt;
      nf_r     <= nf_nxt;
      epoch_r  <= epoch_nxt;
      wrap_r   <= wrap_nxt;
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
  end

`ifndef SYNTHESIS
  a_out_not_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("result and request overlap");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != 3'd0 && {1'b0, idx_r} < cnt_r))
    else $error("result index out of range");
  a_nf_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> ({1'b0, nf_r} < FULL_MARK)) else $error("next code at full mark");
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (epoch_r != '0 && !wrap_r)) else $error("stale slots pending");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(idx_r)))
    else $error("result dropped while stalled");
`endif

endmodule
